[hdl/rcps_pkg.sv]
// Package for the RTCP compound packet splitter.
// Holds the channel payload types, the descriptor queue entry and sizing constants.
// No dependencies.
package rcps_pkg;

   localparam int RCPS_MAX_DATAGRAM_BYTES = 65536;
   localparam int RCPS_POS_W   = 16;
   localparam int RCPS_IDX_W   = 18;
   localparam int RCPS_LEN_W   = 16;
   localparam logic [RCPS_POS_W:0] RCPS_POS_LIMIT = (RCPS_POS_W + 1)'(RCPS_MAX_DATAGRAM_BYTES - 1);

   localparam int RCPS_HDR_BYTES   = 8;
   localparam int RCPS_PAD_BIT     = 5;
   localparam int RCPS_FIFO_DEPTH  = 4;
   localparam int RCPS_FIFO_AW     = $clog2(RCPS_FIFO_DEPTH);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       datagram_end;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] sender_ssrc;
      logic [4:0]  report_count;
      logic [7:0]  packet_type;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
      logic        padding_removed;
   } rsp_payload_type;

   // Raw packet descriptor passed from the parser to the output stage.
   typedef struct packed {
      logic [31:0]           ssrc;
      logic [4:0]            count;
      logic                  pad_flag;
      logic [7:0]            ptype;
      logic [15:0]           offset;
      logic [RCPS_LEN_W-1:0] length_words;
      logic [7:0]            last_byte;
   } rcps_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rcps_fifo_status_type;

endpackage

[hdl/rtcp_compound_packet_splitter.sv]
// Top level of the RTCP compound packet splitter.
// Ties the parser, descriptor queue and output stage together. Depends on rcps_pkg.
//
// Usage:
//  - req_ channel: one datagram byte per transfer (data_byte) with datagram_end
//    set on the final byte. One byte is taken per cycle while req_ready is high.
//  - rsp_ channel: one packet descriptor per complete RTCP packet: SSRC, report
//    count, packet type, payload offset and payload length (padding cut off).
//    Payload bytes are not forwarded.
//  - Path: a packet's descriptor is written into the queue on the transfer of
//    its last byte; the output register loads it from the queue when that
//    register is empty or being read, and rsp_valid then rises.
//  - Throughput: one byte per cycle sustained while the queue is not full; the
//    parser updates all of its header state for each byte.
//  - Stall: when rsp_ready is low, descriptors collect in a four-entry queue;
//    req_ready drops only when that queue is full.
//  - Malformed input: a zero length field, a truncated packet or a short
//    trailing fragment yields no descriptor; parsing resumes at the next
//    datagram.
//  - Reset (synchronous, active high) clears the parser state, the queue and
//    the output valid.
module rtcp_compound_packet_splitter
   import rcps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   rcps_fifo_status_type fifo_status;
   logic                 push;
   logic                 pop;
   rcps_desc_type        push_desc;
   rcps_desc_type        head_desc;

   // byte parser
   rcps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .fifo_status (fifo_status),
      .push        (push),
      .push_desc   (push_desc)
   );

   // decouples the parser from receiver stalls
   rcps_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .status    (fifo_status)
   );

   // padding cut and output register
   rcps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_desc   (head_desc),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[hdl/rcps_front.sv]
// Parser front end: accepts datagram bytes, tracks header fields and packet bounds.
// Pushes one raw descriptor per complete packet. Depends on rcps_pkg.
module rcps_front
   import rcps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   input  rcps_fifo_status_type fifo_status,
   output logic                 push,
   output rcps_desc_type        push_desc
);

   logic [RCPS_POS_W-1:0] pos_ff, pos_in;
   logic [RCPS_IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]            fhb_ff, fhb_in;
   logic [7:0]            type_ff, type_in;
   logic [RCPS_LEN_W-1:0] lw_ff, lw_in;
   logic [31:0]           ssrc_ff, ssrc_in;
   logic [RCPS_POS_W-1:0] start_ff, start_in;
   logic                  halted_ff, halted_in;

   logic                  accept;
   logic [7:0]            b;
   logic [RCPS_IDX_W-1:0] final_idx;
   logic                  done;
   logic                  len_halt;

   assign req_ready = ~fifo_status.full;
   assign accept    = req_valid & req_ready;
   assign b         = req_payload.data_byte;
   assign final_idx = {lw_ff, 2'b11};
   assign done      = (idx_ff >= RCPS_IDX_W'(7)) && (idx_ff == final_idx);

   always_comb begin
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      fhb_in    = fhb_ff;
      type_in   = type_ff;
      lw_in     = lw_ff;
      ssrc_in   = ssrc_ff;
      start_in  = start_ff;
      halted_in = halted_ff;
      len_halt  = 1'b0;
      if (!halted_ff) begin
         if (idx_ff == RCPS_IDX_W'(0)) begin
            fhb_in   = b;
            start_in = pos_ff;
         end else if (idx_ff == RCPS_IDX_W'(1)) begin
            type_in = b;
         end else if (idx_ff == RCPS_IDX_W'(2)) begin
            lw_in = {b, 8'h00};
         end else if (idx_ff == RCPS_IDX_W'(3)) begin
            lw_in = {lw_ff[15:8], b};
            if ({lw_ff[15:8], b} == 16'h0000) begin
               len_halt  = 1'b1;
               halted_in = 1'b1;
            end
         end else if (idx_ff <= RCPS_IDX_W'(7)) begin
            ssrc_in = {ssrc_ff[23:0], b};
         end
         if (!len_halt) begin
            idx_in = done ? '0 : idx_ff + RCPS_IDX_W'(1);
         end
         if ({1'b0, pos_ff} >= RCPS_POS_LIMIT) begin
            halted_in = 1'b1;
         end else begin
            pos_in = pos_ff + RCPS_POS_W'(1);
         end
      end
      if (req_payload.datagram_end) begin
         pos_in    = '0;
         idx_in    = '0;
         halted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         idx_ff    <= '0;
         fhb_ff    <= '0;
         type_ff   <= '0;
         lw_ff     <= '0;
         ssrc_ff   <= '0;
         start_ff  <= '0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         idx_ff    <= idx_in;
         fhb_ff    <= fhb_in;
         type_ff   <= type_in;
         lw_ff     <= lw_in;
         ssrc_ff   <= ssrc_in;
         start_ff  <= start_in;
         halted_ff <= halted_in;
      end
   end

   assign push = accept & ~halted_ff & done;

   always_comb begin
      push_desc.ssrc         = ssrc_in;
      push_desc.count        = fhb_ff[4:0];
      push_desc.pad_flag     = fhb_ff[RCPS_PAD_BIT];
      push_desc.ptype        = type_ff;
      push_desc.offset       = start_ff + RCPS_POS_W'(RCPS_HDR_BYTES);
      push_desc.length_words = lw_ff;
      push_desc.last_byte    = b;
   end

endmodule

[hdl/rcps_fifo.sv]
// Short descriptor queue between the parser and the output stage.
// Depends on rcps_pkg.
module rcps_fifo
   import rcps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rcps_desc_type        push_desc,
   input  logic                 pop,
   output rcps_desc_type        head_desc,
   output rcps_fifo_status_type status
);

   rcps_desc_type           mem [RCPS_FIFO_DEPTH];
   logic [RCPS_FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RCPS_FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RCPS_FIFO_AW:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign status.full  = (count_ff == (RCPS_FIFO_AW + 1)'(RCPS_FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_desc    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + RCPS_FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + RCPS_FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (RCPS_FIFO_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (RCPS_FIFO_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/rcps_back.sv]
// Output stage: takes descriptors from the queue, applies padding removal,
// and holds the result in the output register. Depends on rcps_pkg.
module rcps_back
   import rcps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  rcps_desc_type        head_desc,
   input  rcps_fifo_status_type fifo_status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload
);

   logic                  valid_ff, valid_in;
   rsp_payload_type       data_ff, data_in;
   logic [RCPS_IDX_W-1:0] plen_full;
   logic [RCPS_IDX_W-1:0] plen_cut;
   logic [RCPS_IDX_W-1:0] pad_amt;
   logic                  do_cut;

   assign pop = ~fifo_status.empty & (~valid_ff | rsp_ready);

   // payload bytes = length_words * 4 - 4; length_words is never zero here
   assign plen_full = {head_desc.length_words, 2'b00} - RCPS_IDX_W'(4);
   assign pad_amt   = RCPS_IDX_W'(head_desc.last_byte);
   assign do_cut    = head_desc.pad_flag && (plen_full != '0) && (pad_amt <= plen_full);
   assign plen_cut  = do_cut ? plen_full - pad_amt : plen_full;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (pop) begin
         valid_in                = 1'b1;
         data_in.sender_ssrc     = head_desc.ssrc;
         data_in.report_count    = head_desc.count;
         data_in.packet_type     = head_desc.ptype;
         data_in.payload_offset  = head_desc.offset;
         data_in.payload_length  = plen_cut[15:0];
         data_in.padding_removed = do_cut & (head_desc.last_byte != 8'h00);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule
